[hw/rtl/indexed_sequence_store_defines.svh]
// Assertion macros shared by the indexed sequence store RTL.
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define ISS_ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: assertion failed");

// A condition that must be followed in the next cycle by another.
`define ISS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

[hw/rtl/iss_pkg.sv]
// Types, constants and command codes of the indexed sequence store.
package iss_pkg;

    localparam int CAPACITY = 256;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int CMD_W    = 3;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    typedef struct packed {
        logic              app;
        logic              ins;
        logic              rem;
        logic              get;
        logic [CMP_W-1:0]  pos;
        logic [CMP_W-1:0]  count;
        logic [DATA_W-1:0] value;
    } t_bcast;

endpackage

[hw/rtl/iss_cell.sv]
// One storage cell of the sequence row, shifting with its neighbours.
module iss_cell (
    input  logic                       i_clk,
    input  iss_pkg::t_bcast            i_bc,
    input  logic [iss_pkg::CMP_W-1:0]  i_index,
    input  logic [iss_pkg::DATA_W-1:0] i_left,
    input  logic [iss_pkg::DATA_W-1:0] i_right,
    output logic [iss_pkg::DATA_W-1:0] o_data,
    output logic [iss_pkg::DATA_W-1:0] o_rd
);
    import iss_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_bc.app && i_index == i_bc.count) begin
            n_data = i_bc.value;
        end else if (i_bc.ins && i_index == i_bc.pos) begin
            n_data = i_bc.value;
        end else if (i_bc.ins && i_index > i_bc.pos) begin
            n_data = i_left;
        end else if (i_bc.rem && i_index >= i_bc.pos) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = (i_bc.get && i_index == i_bc.pos) ? r_data : '0;

endmodule

[hw/rtl/indexed_sequence_store.sv]
// Indexed sequence store: a row of cells holding an ordered list of values.
// The store keeps up to CAPACITY signed 32-bit values in a row of cells, one
// value per cell, with a count of the entries in use. Each input beat carries
// one command (append, insert before a position, remove at a position, get or
// clear) and gives exactly one result beat with a success flag, the value read
// and the new count. Insert and remove move every cell behind the position by
// one place together, each cell taking the word of its neighbour, so a new beat
// can be taken every cycle; the result is held in an output register, and input
// is stalled only while that register is full and the output is stalled. The
// get read is an AND-OR selection across the row. Refused commands leave the
// store unchanged.
`include "indexed_sequence_store_defines.svh"

module indexed_sequence_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [iss_pkg::CMD_W-1:0]         i_cmd,
    input  logic [iss_pkg::POS_W-1:0]         i_position,
    input  logic signed [iss_pkg::DATA_W-1:0] i_value_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_ok,
    output logic signed [iss_pkg::DATA_W-1:0] o_value_out,
    output logic [iss_pkg::CNT_W-1:0]         o_count_out
);
    import iss_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic              r_ok;
    logic [DATA_W-1:0] r_value;
    logic              accept;
    logic              in_range;
    logic              full;
    logic              ok;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  count_ext;
    logic [DATA_W-1:0] rd_data;
    t_bcast            bc;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_rd   [CAPACITY];

    assign o_stall   = r_out_valid && i_stall;
    assign accept    = i_valid && !o_stall;
    assign pos_ext   = CMP_W'(i_position);
    assign count_ext = CMP_W'(r_count);
    assign in_range  = pos_ext < count_ext;
    assign full      = r_count == CNT_W'(CAPACITY);

    always_comb begin
        ok      = 1'b0;
        n_count = r_count;
        unique case (i_cmd)
            CMD_APPEND: begin
                ok = !full;
                if (ok) begin
                    n_count = r_count + 1'b1;
                end
            end
            CMD_INSERT: begin
                ok = in_range && !full;
                if (ok) begin
                    n_count = r_count + 1'b1;
                end
            end
            CMD_REMOVE: begin
                ok = in_range;
                if (ok) begin
                    n_count = r_count - 1'b1;
                end
            end
            CMD_GET: begin
                ok = in_range;
            end
            CMD_CLEAR: begin
                ok      = 1'b1;
                n_count = '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        bc.app   = accept && ok && i_cmd == CMD_APPEND;
        bc.ins   = accept && ok && i_cmd == CMD_INSERT;
        bc.rem   = accept && ok && i_cmd == CMD_REMOVE;
        bc.get   = ok && i_cmd == CMD_GET;
        bc.pos   = pos_ext;
        bc.count = count_ext;
        bc.value = i_value_in;
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;

        if (k == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = cell_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = cell_data[k+1];
        end

        iss_cell u_cell (
            .i_clk   (i_clk),
            .i_bc    (bc),
            .i_index (CMP_W'(k)),
            .i_left  (left),
            .i_right (right),
            .o_data  (cell_data[k]),
            .o_rd    (cell_rd[k])
        );
    end

    always_comb begin
        rd_data = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_data = rd_data | cell_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok    <= ok;
            r_value <= rd_data;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_ok        = r_ok;
    assign o_value_out = r_value;
    assign o_count_out = r_count;

    `ISS_ASSERT_HOLDS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `ISS_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, accept && i_cmd == CMD_CLEAR, o_valid && o_ok && o_count_out == '0)
    `ISS_ASSERT_HOLDS(a_refused_zero, i_clk, i_rst_n, !(o_valid && !o_ok) || o_value_out == '0)
    `ISS_ASSERT_NEXT(a_refused_keeps, i_clk, i_rst_n, accept && !ok, r_count == $past(r_count))

endmodule
